// File: sv/hdt_pkg.sv
// Package for the hysteresis dwell trigger: widths, payload structs,
// configuration register codes. No dependencies.
package hdt_pkg;

  localparam int TIME_WIDTH   = 32;
  localparam int SAMPLE_WIDTH = 32;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = (TIME_WIDTH > SAMPLE_WIDTH) ? TIME_WIDTH : SAMPLE_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFF_DWELL      = CFG_IDX_W'(0),
    REG_ON_DWELL       = CFG_IDX_W'(1),
    REG_LOW_THRESHOLD  = CFG_IDX_W'(2),
    REG_HIGH_THRESHOLD = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic        [TIME_WIDTH-1:0]   time_now;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                  level;
    logic [TIME_WIDTH-1:0] dwell_count;
  } out_item_t;

  typedef struct packed {
    logic        [TIME_WIDTH-1:0]   off_dwell;
    logic        [TIME_WIDTH-1:0]   on_dwell;
    logic signed [SAMPLE_WIDTH-1:0] low_threshold;
    logic signed [SAMPLE_WIDTH-1:0] high_threshold;
  } cfg_regs_t;

endpackage

// File: sv/hysteresis_dwell_trigger.sv
// Hysteresis dwell trigger top level. Depends on hdt_pkg and hdt_step.
// Each request passes the input register, then the result register, before
// out_valid rises. One request per cycle while the result side does not stall;
// the level/timer update is a combinational compare, subtract and saturating
// add.
// Reset (synchronous, rst_n low): level high, timer and last timestamp 0,
// all configuration registers 0, both pipeline stages empty.
module hysteresis_dwell_trigger (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  hdt_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output hdt_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hdt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hdt_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import hdt_pkg::*;

  cfg_regs_t cfg_r;
  in_item_t  s1_data_r;
  logic      s1_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t step_res;
  logic      s1_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFF_DWELL:      cfg_r.off_dwell      <= cfg_data[TIME_WIDTH-1:0];
        REG_ON_DWELL:       cfg_r.on_dwell       <= cfg_data[TIME_WIDTH-1:0];
        REG_LOW_THRESHOLD:  cfg_r.low_threshold  <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_HIGH_THRESHOLD: cfg_r.high_threshold <= cfg_data[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  hdt_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .item  (s1_data_r),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_s1_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted request lost at input register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("stalled input register changed");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && (out_data_r == $past(step_res)))
    else $error("result register missed an update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !s1_adv)
    else $error("pending result overwritten");

endmodule

// File: sv/hdt_step.sv
// Trigger state (level, dwell timer, last timestamp) and its registered update.
// Depends on hdt_pkg.
module hdt_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  hdt_pkg::in_item_t  item,
  input  hdt_pkg::cfg_regs_t cfg,
  output hdt_pkg::out_item_t res
);
  import hdt_pkg::*;

  logic                  level_r, level_nxt;
  logic [TIME_WIDTH-1:0] timer_r, timer_nxt;
  logic [TIME_WIDTH-1:0] last_r;

  logic [TIME_WIDTH-1:0] delta;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] added;
  logic                  qualify;
  logic [TIME_WIDTH-1:0] dwell;

  always_comb begin
    // backwards steps add nothing
    delta = (item.time_now >= last_r) ? (item.time_now - last_r) : '0;
    sum   = {1'b0, timer_r} + {1'b0, delta};
    added = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];

    if (!level_r) begin
      qualify = (item.sample >= cfg.high_threshold);
      dwell   = cfg.on_dwell;
    end else begin
      qualify = (item.sample <= cfg.low_threshold);
      dwell   = cfg.off_dwell;
    end

    level_nxt = level_r;
    timer_nxt = '0;
    if (qualify) begin
      if (timer_r > dwell) begin
        // flip; timer carried into the new state
        level_nxt = ~level_r;
        timer_nxt = timer_r;
      end else begin
        timer_nxt = added;
      end
    end
  end

  assign res.level       = level_nxt;
  assign res.dwell_count = timer_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b1;
      timer_r <= '0;
      last_r  <= '0;
    end else if (en) begin
      level_r <= level_nxt;
      timer_r <= timer_nxt;
      last_r  <= item.time_now;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(level_r) && $stable(timer_r) && $stable(last_r))
    else $error("trigger state moved without a request");

  a_flip_keeps_timer: assert property (@(posedge clk) disable iff (!rst_n)
    en && (level_nxt != level_r) |=> $stable(timer_r))
    else $error("timer changed on a level transition");

  a_clear_when_unqualified: assert property (@(posedge clk) disable iff (!rst_n)
    en && !qualify |=> timer_r == '0)
    else $error("timer not cleared by an unqualified sample");

endmodule

// File: bench/tb_top.sv
// Testbench for hysteresis_dwell_trigger: random and directed sample streams,
// scoreboard with its own level/dwell predictor. Depends on hdt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import hdt_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SAMPLE_ITEMS = 1850;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = '1;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] ONE_Q16 = 65536;

  class dwell_scoreboard;
    logic [TIME_WIDTH-1:0] off_dwell, on_dwell;
    logic signed [SAMPLE_WIDTH-1:0] low_thr, high_thr;
    logic level;
    logic [TIME_WIDTH-1:0] timer, last_time;
    out_item_t expected_levels[$];
    int errors;

    function new();
      off_dwell = '0;
      on_dwell  = '0;
      low_thr   = '0;
      high_thr  = '0;
      level     = 1'b1;
      timer     = '0;
      last_time = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_OFF_DWELL:      off_dwell = val[TIME_WIDTH-1:0];
        REG_ON_DWELL:       on_dwell  = val[TIME_WIDTH-1:0];
        REG_LOW_THRESHOLD:  low_thr   = val[SAMPLE_WIDTH-1:0];
        REG_HIGH_THRESHOLD: high_thr  = val[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // saturating add of the forward time step; backward steps add nothing
    function void accumulate_dwell(logic [TIME_WIDTH-1:0] tnow);
      logic [TIME_WIDTH:0] sum;
      logic [TIME_WIDTH-1:0] delta;
      delta = (tnow >= last_time) ? tnow - last_time : '0;
      sum = {1'b0, timer} + {1'b0, delta};
      timer = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
    endfunction

    function void note_sample(in_item_t d);
      out_item_t exp_item;
      logic signed [SAMPLE_WIDTH-1:0] s;
      s = d.sample;
      if (!level) begin
        if (s >= high_thr) begin
          if (timer > on_dwell) level = 1'b1;
          else accumulate_dwell(d.time_now);
        end else begin
          timer = '0;
        end
      end else begin
        if (s <= low_thr) begin
          if (timer > off_dwell) level = 1'b0;
          else accumulate_dwell(d.time_now);
        end else begin
          timer = '0;
        end
      end
      last_time = d.time_now;
      exp_item.level = level;
      exp_item.dwell_count = timer;
      expected_levels.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: level=%0b dwell_count=%0d", got.level, got.dwell_count);
        return;
      end
      exp_item = expected_levels.pop_front();
      if (got.level !== exp_item.level || got.dwell_count !== exp_item.dwell_count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: level exp %0b got %0b, dwell_count exp %0d got %0d",
                   exp_item.level, got.level, exp_item.dwell_count, got.dwell_count);
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dwell_scoreboard sb = new();
  int cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  logic [TIME_WIDTH-1:0] tstamp = '0;

  always #2 clk = ~clk;

  hysteresis_dwell_trigger i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side: random stall drawn per result, bursts with no stall
  always @(posedge clk) begin : result_sink
    int stall;
    int wait_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      wait_left = 0;
    end else if (out_valid && out_ready) begin
      sb.check_result(out_data);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        wait_left = stall - 1;
      end
    end else if (!out_ready) begin
      if (wait_left == 0) out_ready <= 1'b1;
      else wait_left = wait_left - 1;
    end
  end

  // leaves in_valid high on return; the next request or the caller lowers it
  task automatic send_sample(input logic [TIME_WIDTH-1:0] t,
                             input logic signed [SAMPLE_WIDTH-1:0] s);
    in_item_t d;
    int gap;
    d.time_now = t;
    d.sample = s;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(d);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [TIME_WIDTH-1:0] offd, input logic [TIME_WIDTH-1:0] ond,
                           input logic signed [SAMPLE_WIDTH-1:0] lo,
                           input logic signed [SAMPLE_WIDTH-1:0] hi, input bit stray);
    write_reg(REG_OFF_DWELL, offd);
    write_reg(REG_ON_DWELL, ond);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    if (stray)
      write_reg($urandom_range(0, 1) ? UNMAPPED_REG
                                     : CFG_IDX_W'($urandom_range(REG_HIGH_THRESHOLD + 1, 254)),
                $urandom());
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int sent;
    int n_phase;
    logic [TIME_WIDTH-1:0] dw[2];
    logic signed [SAMPLE_WIDTH-1:0] lo, hi, centre, s;
    bit side_high;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: zero dwells and thresholds, level starts high
    send_sample(0, 0);
    send_sample(5, SAMPLE_MIN);
    send_sample(6, -1);
    send_sample(6, 0);
    send_sample(9, 1);
    send_sample(12, SAMPLE_MAX);
    send_sample(12, SAMPLE_MIN);
    send_sample(4, -5);
    send_sample(20, -5);
    send_sample(18, -5);
    drain_results();

    // dwells never reached: backward steps and timer saturation
    configure(TIME_MAX, TIME_MAX, 0, 0, 1'b1);
    send_sample(100, 0);
    send_sample(50, 0);
    send_sample(0, 0);
    send_sample(TIME_MAX, 0);
    send_sample(TIME_MAX, 0);
    send_sample(TIME_MAX, 1);
    drain_results();

    // samples exactly at and just past each threshold
    configure(3, 2, -ONE_Q16, ONE_Q16, 1'b0);
    send_sample(1, ONE_Q16 - 1);
    send_sample(3, -ONE_Q16);
    send_sample(8, -ONE_Q16 - 1);
    send_sample(10, -ONE_Q16);
    send_sample(11, ONE_Q16);
    send_sample(15, ONE_Q16);
    drain_results();

    configure(0, 32'h8000_0000, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_sample(30, SAMPLE_MIN);
    send_sample(31, SAMPLE_MIN);
    send_sample(32, SAMPLE_MAX);
    send_sample(40, 0);
    drain_results();

    tstamp = 40;
    sent = 26;
    while (sent < SAMPLE_ITEMS) begin
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 9))
          0: dw[k] = '0;
          1: dw[k] = TIME_MAX;
          2: dw[k] = $urandom();
          default: dw[k] = $urandom_range(0, 40);
        endcase
      end
      case ($urandom_range(0, 9))
        0: begin lo = SAMPLE_MIN; hi = SAMPLE_MAX; end
        1: begin lo = SAMPLE_MAX; hi = SAMPLE_MIN; end
        2: begin lo = $urandom(); hi = $urandom(); end
        default: begin
          centre = $urandom();
          lo = centre - $urandom_range(0, 1000);
          hi = centre + $urandom_range(0, 1000);
        end
      endcase
      configure(dw[0], dw[1], lo, hi, $urandom_range(0, 2) == 0);

      n_phase = $urandom_range(40, 160);
      side_high = $urandom_range(0, 1);
      for (int i = 0; i < n_phase && sent < SAMPLE_ITEMS; i++) begin
        // runs of qualifying samples, with some noise mixed in
        if ($urandom_range(0, 5) == 0) side_high = !side_high;
        case ($urandom_range(0, 19))
          0: s = $urandom();
          1: s = $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
          2: s = side_high ? hi : lo;
          default: s = side_high ? hi + $urandom_range(0, 500) : lo - $urandom_range(0, 500);
        endcase
        case ($urandom_range(0, 99))
          0, 1, 2: tstamp = tstamp - $urandom_range(0, 1000);
          3, 4: tstamp = $urandom();
          default: tstamp = tstamp + $urandom_range(0, 12);
        endcase
        send_sample(tstamp, s);
        sent++;
        if ($urandom_range(0, 149) == 0) drain_results();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
